[hdl/tsb_pkg.sv]
// ----------------------------------------------------------------------------
// tsb_pkg: shared types and constants of the texture sampler
// Beat layouts, register indexes, wrap codes and the sRGB decode table.
// ----------------------------------------------------------------------------
package tsb_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int SIZE_W     = 13;

  localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_U       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_V       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER       = 3'd5;

  localparam logic [1:0] WRAP_REPEAT = 2'd0;
  localparam logic [1:0] WRAP_CLAMP  = 2'd1;
  localparam logic [1:0] WRAP_MIRROR = 2'd2;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  localparam logic FMT_UNORM = 1'b0;
  localparam logic FMT_SRGB  = 1'b1;

  localparam logic [63:0] Q31_ONE  = 64'h8000_0000;
  localparam logic [63:0] Q31_HALF = 64'h4000_0000;

  typedef struct packed {
    logic               action;
    logic [11:0]        texel_addr;
    logic [31:0]        texel_rgba;
    logic signed [31:0] coord_u;
    logic signed [31:0] coord_v;
  } in_item_t;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] alpha;
  } out_item_t;

  typedef logic [15:0] srgb_lut_t [256];

  function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
    return (a * b + Q31_HALF) >> 31;
  endfunction

  function automatic logic [63:0] qpow5(input logic [63:0] y);
    logic [63:0] y2;
    y2 = qmul(y, y);
    return qmul(qmul(y2, y2), y);
  endfunction

  // Evaluated at elaboration only: a^2.4 as a^2 times the fifth root of a^2.
  function automatic srgb_lut_t srgb_build();
    srgb_lut_t   lut;
    logic [63:0] c;
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] x;
    for (int i = 0; i < 256; i++) begin
      c = 64'(i);
      if (i <= 10) begin
        lut[i] = 16'((c * 64'd6553500 + 64'd164730) / 64'd329460);
      end else begin
        a  = (((64'd1000 * c + 64'd14025) << 31) + 64'd134512) / 64'd269025;
        a2 = qmul(a, a);
        lo = 64'd0;
        hi = Q31_ONE;
        while (lo < hi) begin
          mid = lo + ((hi - lo + 64'd1) >> 1);
          if (qpow5(mid) <= a2) begin
            lo = mid;
          end else begin
            hi = mid - 64'd1;
          end
        end
        x = qmul(a2, lo);
        lut[i] = 16'((x * 64'd65535 + Q31_HALF) >> 31);
      end
    end
    return lut;
  endfunction

  localparam srgb_lut_t SRGB_LUT = srgb_build();

  function automatic logic [15:0] decode_ch(input logic [7:0] b, input logic srgb);
    return srgb ? SRGB_LUT[b] : {b, b};
  endfunction

endpackage

[hdl/texture_sampler_bilinear_wrap.sv]
// ----------------------------------------------------------------------------
// texture_sampler_bilinear_wrap: bilinear texture sampler with wrap modes
// Texel writes and samples share one input stream; samples return RGBA16.
// ----------------------------------------------------------------------------
// The sampler takes one beat per cycle, writes and samples alike, while the
// output is not held, and presents a result for each sample. The texel store is
// kept in four copies, each with its own read port, so that the four bilinear
// taps are read in the same cycle; writes go to all copies at the same pipeline
// point as reads, so every sample sees exactly the writes that were accepted
// before it. Texels must be written before they are sampled; the store has no
// clearing pass. Registers are to be written by the user only while no beat is
// in flight; the block itself does not enforce this.
module texture_sampler_bilinear_wrap #(
  parameter int TEXEL_WORDS = 4096,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  tsb_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output tsb_pkg::out_item_t                 out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tsb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tsb_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import tsb_pkg::*;

  localparam int AW = $clog2(TEXEL_WORDS);
  localparam int NS = 13;

  typedef struct packed {
    logic          wr;
    logic          smp;
    logic [AW-1:0] addr;
    logic [31:0]   data;
    logic          bad;
  } side_t;

  // Configuration registers.
  logic [SIZE_W-1:0] tex_width_r;
  logic [SIZE_W-1:0] tex_height_r;
  logic              pixel_format_r;
  logic [1:0]        wrap_u_r;
  logic [1:0]        wrap_v_r;
  logic              filter_r;
  logic              tex_bad;
  logic [25:0]       area;

  assign cfg_ready = 1'b1;
  assign area      = tex_width_r * tex_height_r;
  assign tex_bad   = (tex_width_r == '0) || (tex_height_r == '0) ||
                     ({1'b0, area} > 27'(TEXEL_WORDS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_width_r    <= '0;
      tex_height_r   <= '0;
      pixel_format_r <= FMT_UNORM;
      wrap_u_r       <= WRAP_REPEAT;
      wrap_v_r       <= WRAP_REPEAT;
      filter_r       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_TEX_WIDTH:    tex_width_r    <= cfg_data;
          REG_TEX_HEIGHT:   tex_height_r   <= cfg_data;
          REG_PIXEL_FORMAT: pixel_format_r <= cfg_data[0];
          REG_WRAP_U:       wrap_u_r       <= cfg_data[1:0];
          REG_WRAP_V:       wrap_v_r       <= cfg_data[1:0];
          REG_FILTER:       filter_r       <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // Stage enables: a stage loads when it is empty or its successor moves.
  logic [NS:1] v_r;
  logic [NS:1] en;

  always_comb begin
    en[NS] = !v_r[NS] || out_ready;
    for (int k = NS - 1; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready = en[1];

  side_t side_r [1:10];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) begin
        v_r[1] <= in_valid;
      end
      for (int k = 2; k <= NS; k++) begin
        if (en[k]) begin
          // Write beats end at the store and produce no result.
          v_r[k] <= (k == 10) ? (v_r[9] && side_r[9].smp) : v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      side_r[1].wr   <= (in_data.action == ACT_WRITE) &&
                        (32'(in_data.texel_addr) < 32'(TEXEL_WORDS));
      side_r[1].smp  <= (in_data.action == ACT_SAMPLE);
      side_r[1].addr <= AW'(in_data.texel_addr);
      side_r[1].data <= in_data.texel_rgba;
      side_r[1].bad  <= tex_bad;
    end
    for (int k = 2; k <= 10; k++) begin
      if (en[k]) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // Coordinate pipelines, stages 1 to 8.
  logic [SIZE_W-1:0]      xa;
  logic [SIZE_W-1:0]      xb;
  logic [SIZE_W-1:0]      ya;
  logic [SIZE_W-1:0]      yb;
  logic [WEIGHT_BITS-1:0] tx8;
  logic [WEIGHT_BITS-1:0] ty8;

  tsb_wrap #(.W(WEIGHT_BITS)) u_wrap_u (
    .clk   (clk),
    .en    (en[8:1]),
    .coord (in_data.coord_u),
    .size  (tex_width_r),
    .mode  (wrap_u_r),
    .lin   (filter_r),
    .idx_a (xa),
    .idx_b (xb),
    .frac  (tx8)
  );

  tsb_wrap #(.W(WEIGHT_BITS)) u_wrap_v (
    .clk   (clk),
    .en    (en[8:1]),
    .coord (in_data.coord_v),
    .size  (tex_height_r),
    .mode  (wrap_v_r),
    .lin   (filter_r),
    .idx_a (ya),
    .idx_b (yb),
    .frac  (ty8)
  );

  // Stage 9: store addresses of the four taps. Nearest mode has zero weights.
  logic [25:0]            row_a;
  logic [25:0]            row_b;
  logic [26:0]            sum_nxt [4];
  logic [AW-1:0]          raddr_r [4];
  logic [WEIGHT_BITS-1:0] tx9_r;
  logic [WEIGHT_BITS-1:0] ty9_r;

  always_comb begin
    row_a      = ya * tex_width_r;
    row_b      = yb * tex_width_r;
    sum_nxt[0] = 27'(row_a) + 27'(xa);
    sum_nxt[1] = 27'(row_a) + 27'(xb);
    sum_nxt[2] = 27'(row_b) + 27'(xa);
    sum_nxt[3] = 27'(row_b) + 27'(xb);
  end

  always_ff @(posedge clk) begin
    if (en[9]) begin
      for (int n = 0; n < 4; n++) begin
        raddr_r[n] <= sum_nxt[n][AW-1:0];
      end
      tx9_r <= tx8;
      ty9_r <= ty8;
    end
  end

  // Stage 10: store access.
  logic                   ram_we;
  logic [3:0][31:0]       texels;
  logic [WEIGHT_BITS-1:0] tx10_r;
  logic [WEIGHT_BITS-1:0] ty10_r;

  assign ram_we = en[10] && v_r[9] && side_r[9].wr;

  for (genvar g = 0; g < 4; g++) begin : g_store
    tsb_ram #(.WIDTH(32), .DEPTH(TEXEL_WORDS)) u_ram (
      .clk   (clk),
      .we    (ram_we),
      .waddr (side_r[9].addr),
      .wdata (side_r[9].data),
      .re    (en[10]),
      .raddr (raddr_r[g]),
      .rdata (texels[g])
    );
  end

  always_ff @(posedge clk) begin
    if (en[10]) begin
      tx10_r <= filter_r ? tx9_r : '0;
      ty10_r <= filter_r ? ty9_r : '0;
    end
  end

  // Stages 11 to 13.
  tsb_blend #(.W(WEIGHT_BITS)) u_blend (
    .clk    (clk),
    .en     (en[13:11]),
    .texels (texels),
    .tx     (tx10_r),
    .ty     (ty10_r),
    .srgb   (pixel_format_r),
    .bad    (side_r[10].bad),
    .result (out_data)
  );

  assign out_valid = v_r[NS];

  a_idle_ready : assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with no result waiting");

  a_drain_ready : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |-> in_ready)
    else $error("input stalled while the output beat moves");

  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

[hdl/tsb_ram.sv]
// ----------------------------------------------------------------------------
// tsb_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tsb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/tsb_wrap.sv]
// ----------------------------------------------------------------------------
// tsb_wrap: per-axis coordinate pipeline
// Scales one coordinate by the texture size, splits it into texel index and
// blend weight, and wraps the two neighbor indexes (eight stages).
// ----------------------------------------------------------------------------
module tsb_wrap #(
  parameter int W = 16
) (
  input  logic                         clk,
  input  logic [7:0]                   en,
  input  logic signed [31:0]           coord,
  input  logic [tsb_pkg::SIZE_W-1:0]   size,
  input  logic [1:0]                   mode,
  input  logic                         lin,
  output logic [tsb_pkg::SIZE_W-1:0]   idx_a,
  output logic [tsb_pkg::SIZE_W-1:0]   idx_b,
  output logic [W-1:0]                 frac
);
  import tsb_pkg::*;

  // Remainder by the wrap period, 8 restoring steps per stage.
  function automatic logic [45:0] mod_step8(input logic [13:0] r_in, input logic [31:0] q_in,
                                            input logic [13:0] p);
    logic [14:0] tmp;
    logic [13:0] r;
    logic [31:0] q;
    r = r_in;
    q = q_in;
    for (int k = 0; k < 8; k++) begin
      tmp = {r, q[31]};
      q   = {q[30:0], 1'b0};
      if (tmp >= {1'b0, p}) begin
        tmp = tmp - {1'b0, p};
      end
      r = tmp[13:0];
    end
    return {r, q};
  endfunction

  logic [13:0] per;
  assign per = (mode == WRAP_MIRROR) ? {size, 1'b0} : {1'b0, size};

  // Stage 1: scale.
  logic signed [45:0] prod_r;
  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod_r <= coord * $signed({1'b0, size});
    end
  end

  // Stage 2: half-texel offset in linear mode, floor, fraction, magnitude.
  logic signed [45:0] f_nxt;
  logic signed [29:0] x0_nxt;
  logic [29:0]        mag_nxt;
  always_comb begin
    f_nxt   = prod_r - (lin ? 46'sd32768 : 46'sd0);
    x0_nxt  = f_nxt[45:16];
    mag_nxt = f_nxt[45] ? 30'(-x0_nxt) : 30'(x0_nxt);
  end

  logic [13:0]        rem_r [5];
  logic [31:0]        quo_r [5];
  logic signed [29:0] x0_r  [5];
  logic               neg_r [5];
  logic [W-1:0]       t_r   [5];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      rem_r[0] <= 14'd0;
      quo_r[0] <= {2'b00, mag_nxt};
      x0_r[0]  <= x0_nxt;
      neg_r[0] <= f_nxt[45];
      t_r[0]   <= f_nxt[15:16-W];
    end
  end

  // Stages 3 to 6: remainder of the magnitude by the period.
  for (genvar g = 1; g < 5; g++) begin : g_mod
    always_ff @(posedge clk) begin
      if (en[g+1]) begin
        {rem_r[g], quo_r[g]} <= mod_step8(rem_r[g-1], quo_r[g-1], per);
        x0_r[g]  <= x0_r[g-1];
        neg_r[g] <= neg_r[g-1];
        t_r[g]   <= t_r[g-1];
      end
    end
  end

  // Stage 7: signed remainder for both neighbors.
  logic [13:0]        m0_nxt;
  logic [13:0]        m1_nxt;
  logic [13:0]        m0_r;
  logic [13:0]        m1_r;
  logic signed [29:0] x0s_r;
  logic signed [29:0] x1s_r;
  logic [W-1:0]       t7_r;

  always_comb begin
    m0_nxt = (neg_r[4] && rem_r[4] != 14'd0) ? per - rem_r[4] : rem_r[4];
    m1_nxt = (m0_nxt == per - 14'd1) ? 14'd0 : m0_nxt + 14'd1;
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      m0_r  <= m0_nxt;
      m1_r  <= m1_nxt;
      x0s_r <= x0_r[4];
      x1s_r <= x0_r[4] + 30'sd1;
      t7_r  <= t_r[4];
    end
  end

  // Stage 8: apply the wrap mode.
  function automatic logic [SIZE_W-1:0] clampi(input logic signed [29:0] x,
                                               input logic [SIZE_W-1:0] sz);
    if (x < 30'sd0) begin
      return '0;
    end else if (x >= $signed({17'd0, sz})) begin
      return sz - 13'd1;
    end
    return x[SIZE_W-1:0];
  endfunction

  function automatic logic [SIZE_W-1:0] fold(input logic [13:0] m, input logic [13:0] p,
                                             input logic [SIZE_W-1:0] sz);
    logic [13:0] r;
    r = (m < {1'b0, sz}) ? m : p - 14'd1 - m;
    return r[SIZE_W-1:0];
  endfunction

  logic [SIZE_W-1:0] a_nxt;
  logic [SIZE_W-1:0] b_nxt;
  logic [SIZE_W-1:0] a_r;
  logic [SIZE_W-1:0] b_r;
  logic [W-1:0]      t8_r;

  always_comb begin
    unique case (mode)
      WRAP_CLAMP: begin
        a_nxt = clampi(x0s_r, size);
        b_nxt = clampi(x1s_r, size);
      end
      WRAP_MIRROR: begin
        a_nxt = fold(m0_r, per, size);
        b_nxt = fold(m1_r, per, size);
      end
      default: begin
        a_nxt = m0_r[SIZE_W-1:0];
        b_nxt = m1_r[SIZE_W-1:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      a_r  <= a_nxt;
      b_r  <= b_nxt;
      t8_r <= t7_r;
    end
  end

  assign idx_a = a_r;
  assign idx_b = b_r;
  assign frac  = t8_r;

endmodule

[hdl/tsb_blend.sv]
// ----------------------------------------------------------------------------
// tsb_blend: texel decode and bilinear blend
// Decodes four texels to 16-bit channels, blends across then down
// (three stages).
// ----------------------------------------------------------------------------
module tsb_blend #(
  parameter int W = 16
) (
  input  logic                    clk,
  input  logic [2:0]              en,
  input  logic [3:0][31:0]        texels,
  input  logic [W-1:0]            tx,
  input  logic [W-1:0]            ty,
  input  logic                    srgb,
  input  logic                    bad,
  output tsb_pkg::out_item_t      result
);
  import tsb_pkg::*;

  function automatic logic [15:0] lerp(input logic [15:0] a, input logic [15:0] b,
                                       input logic [W-1:0] t);
    logic [33:0] s;
    s = 34'(a) * (34'(2**W) - 34'(t)) + 34'(b) * 34'(t) + 34'(2**(W-1));
    return s[W+15:W];
  endfunction

  // Stage 11: decode; texel order is top-left, top-right, bottom-left, bottom-right.
  logic [3:0][3:0][15:0] dec_r;
  logic [W-1:0]          tx11_r;
  logic [W-1:0]          ty11_r;
  logic                  bad11_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int n = 0; n < 4; n++) begin
        for (int k = 0; k < 4; k++) begin
          dec_r[n][k] <= decode_ch(texels[n][8*k +: 8], (srgb == FMT_SRGB) && (k < 3));
        end
      end
      tx11_r  <= tx;
      ty11_r  <= ty;
      bad11_r <= bad;
    end
  end

  // Stage 12: horizontal blend on both rows.
  logic [3:0][15:0] top_r;
  logic [3:0][15:0] bot_r;
  logic [W-1:0]     ty12_r;
  logic             bad12_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int k = 0; k < 4; k++) begin
        top_r[k] <= lerp(dec_r[0][k], dec_r[1][k], tx11_r);
        bot_r[k] <= lerp(dec_r[2][k], dec_r[3][k], tx11_r);
      end
      ty12_r  <= ty11_r;
      bad12_r <= bad11_r;
    end
  end

  // Stage 13: vertical blend; an unusable texture reads as white.
  logic [3:0][15:0] res_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int k = 0; k < 4; k++) begin
        res_r[k] <= bad12_r ? 16'hFFFF : lerp(top_r[k], bot_r[k], ty12_r);
      end
    end
  end

  assign result.red   = res_r[0];
  assign result.green = res_r[1];
  assign result.blue  = res_r[2];
  assign result.alpha = res_r[3];

endmodule
